>>> rtl/core/ps2_keyboard_command_responder_assert.svh
// Assertion macros shared by the responder RTL.
`ifndef PS2_KEYBOARD_COMMAND_RESPONDER_ASSERT_SVH
`define PS2_KEYBOARD_COMMAND_RESPONDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2KBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2kbd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PS2KBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2kbd: next-cycle check failed");

`endif

>>> rtl/core/ps2kbd_pkg.sv
package ps2kbd_pkg;

    // Host commands
    localparam logic [7:0] CMD_SET_LED    = 8'hED;
    localparam logic [7:0] CMD_PING       = 8'hEE;
    localparam logic [7:0] CMD_SCAN_SET   = 8'hF0;
    localparam logic [7:0] CMD_READ_ID    = 8'hF2;
    localparam logic [7:0] CMD_TYPEMATIC  = 8'hF3;
    localparam logic [7:0] CMD_ENABLE     = 8'hF4;
    localparam logic [7:0] CMD_DISABLE    = 8'hF5;
    localparam logic [7:0] CMD_DEFAULTS   = 8'hF6;
    localparam logic [7:0] CMD_ACK_ONLY_LO = 8'hF7;
    localparam logic [7:0] CMD_ACK_ONLY_HI = 8'hFD;
    localparam logic [7:0] CMD_REPEAT     = 8'hFE;
    localparam logic [7:0] CMD_RESET      = 8'hFF;

    // Device replies
    localparam logic [7:0] CODE_ACK    = 8'hFA;
    localparam logic [7:0] CODE_RESEND = 8'hFE;
    localparam logic [7:0] CODE_BAT_OK = 8'hAA;
    localparam logic [7:0] CODE_ECHO   = 8'hEE;

    // Pending argument codes
    localparam logic [1:0] ARG_NONE = 2'd0;
    localparam logic [1:0] ARG_LED  = 2'd1;
    localparam logic [1:0] ARG_SET  = 2'd2;
    localparam logic [1:0] ARG_TYPE = 2'd3;

    // Power-up and default values
    localparam logic [2:0] LEDS_ALL_ON   = 3'b111;
    localparam logic [1:0] SET_DEFAULT   = 2'd2;
    localparam logic [1:0] DELAY_DEFAULT = 2'd1;
    localparam logic [4:0] RATE_DEFAULT  = 5'h0B;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       last_of_run;
        logic       led_scroll;
        logic       led_num;
        logic       led_caps;
        logic [1:0] code_set;
        logic [9:0] delay_ms;
        logic [4:0] rate_code;
        logic       scan_enabled;
    } rsp_t;

    // Typematic delay code to milliseconds
    function automatic logic [9:0] delay_ms_of(input logic [1:0] code);
        logic [9:0] ms;
        case (code)
            2'd0:    ms = 10'd250;
            2'd1:    ms = 10'd500;
            2'd2:    ms = 10'd750;
            default: ms = 10'd1000;
        endcase
        return ms;
    endfunction

endpackage

>>> rtl/core/ps2kbd_cmd_if.sv
interface ps2kbd_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] host_byte;

    modport source (output valid, output host_byte, input ready);
    modport sink (input valid, input host_byte, output ready);
endinterface

>>> rtl/core/ps2kbd_rsp_if.sv
interface ps2kbd_rsp_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       last_of_run;
    logic       led_scroll;
    logic       led_num;
    logic       led_caps;
    logic [1:0] code_set;
    logic [9:0] delay_ms;
    logic [4:0] rate_code;
    logic       scan_enabled;

    modport source (
        output valid, output send_valid, output send_byte, output last_of_run,
        output led_scroll, output led_num, output led_caps, output code_set,
        output delay_ms, output rate_code, output scan_enabled,
        input ready
    );
    modport sink (
        input valid, input send_valid, input send_byte, input last_of_run,
        input led_scroll, input led_num, input led_caps, input code_set,
        input delay_ms, input rate_code, input scan_enabled,
        output ready
    );
endinterface

>>> rtl/core/ps2_keyboard_command_responder.sv
// Device side of the PS/2 host command set. Each host byte on cmd yields one
// response item on rsp, or two for the self-test commands F6 and FF (FA, then
// AA); a response item with send_valid low means nothing goes on the wire (an
// argument byte). Every item also carries the LED, scan set, typematic and
// enable state as it stands after that host byte. A host byte is registered
// on acceptance and resolved into a response once the output register is
// free. The block takes one host byte per cycle while responses drain; a
// two-byte reply holds the output register for its FA and then its AA, and
// the next host byte waits in the input register meanwhile.
module ps2_keyboard_command_responder (
    input  logic         clk,
    input  logic         rst_n,
    ps2kbd_cmd_if.sink   cmd,
    ps2kbd_rsp_if.source rsp
);
    import ps2kbd_pkg::*;

`include "ps2_keyboard_command_responder_assert.svh"

    // Input register
    logic       hold_valid_reg;
    logic [7:0] byte_reg;

    // Keyboard state
    logic [1:0] pend_reg,   pend_next;
    logic [7:0] last_reg,   last_next;
    logic [2:0] led_reg,    led_next;
    logic [1:0] set_reg,    set_next;
    logic [1:0] delay_reg,  delay_next;
    logic [4:0] rate_reg,   rate_next;
    logic       enable_reg, enable_next;

    // Output register
    logic out_valid_reg;
    logic second_reg;
    rsp_t out_reg;

    // Resolved reply for the held byte
    logic       snd_valid;
    logic [7:0] snd_byte;
    logic       two_items;
    rsp_t       res;

    logic out_fire;
    logic out_free;
    logic advance;

    assign out_fire = out_valid_reg && rsp.ready;
    assign out_free = !out_valid_reg || (rsp.ready && !second_reg);
    assign advance  = hold_valid_reg && out_free;
    assign cmd.ready = !hold_valid_reg || out_free;

    // Decode the held byte against the current state
    always_comb
    begin
        pend_next   = pend_reg;
        last_next   = last_reg;
        led_next    = led_reg;
        set_next    = set_reg;
        delay_next  = delay_reg;
        rate_next   = rate_reg;
        enable_next = enable_reg;
        snd_valid   = 1'b1;
        snd_byte    = CODE_ACK;
        two_items   = 1'b0;

        if (pend_reg != ARG_NONE)
        begin
            // Argument byte: applied to the pending setting, never acknowledged
            pend_next = ARG_NONE;
            snd_valid = 1'b0;
            snd_byte  = 8'h00;
            unique case (pend_reg)
                ARG_LED:
                begin
                    led_next = byte_reg[2:0];
                end
                ARG_SET:
                begin
                    if (byte_reg == 8'h00)
                    begin
                        // Query: report the current set
                        snd_valid = 1'b1;
                        snd_byte  = {6'b0, set_reg};
                        last_next = {6'b0, set_reg};
                    end
                    else if (byte_reg <= 8'd3)
                    begin
                        set_next = byte_reg[1:0];
                    end
                    else
                    begin
                        set_next = SET_DEFAULT;
                    end
                end
                ARG_TYPE:
                begin
                    delay_next = byte_reg[6:5];
                    rate_next  = byte_reg[4:0];
                end
                default:
                begin
                    pend_next = ARG_NONE;
                end
            endcase
        end
        else
        begin
            unique case (byte_reg) inside
                CMD_SET_LED:
                begin
                    pend_next = ARG_LED;
                    last_next = CODE_ACK;
                end
                CMD_SCAN_SET:
                begin
                    pend_next = ARG_SET;
                    last_next = CODE_ACK;
                end
                CMD_TYPEMATIC:
                begin
                    pend_next = ARG_TYPE;
                    last_next = CODE_ACK;
                end
                CMD_PING:
                begin
                    snd_byte  = CODE_ECHO;
                    last_next = CODE_ECHO;
                end
                CMD_READ_ID, [CMD_ACK_ONLY_LO:CMD_ACK_ONLY_HI]:
                begin
                    last_next = CODE_ACK;
                end
                CMD_ENABLE:
                begin
                    last_next   = CODE_ACK;
                    enable_next = 1'b1;
                end
                CMD_DISABLE:
                begin
                    delay_next  = DELAY_DEFAULT;
                    rate_next   = RATE_DEFAULT;
                    set_next    = SET_DEFAULT;
                    last_next   = 8'h00;
                    enable_next = 1'b0;
                end
                CMD_DEFAULTS, CMD_RESET:
                begin
                    // Self test: FA now, AA next
                    led_next    = LEDS_ALL_ON;
                    delay_next  = DELAY_DEFAULT;
                    rate_next   = RATE_DEFAULT;
                    set_next    = SET_DEFAULT;
                    enable_next = 1'b1;
                    last_next   = CODE_BAT_OK;
                    two_items   = 1'b1;
                end
                CMD_REPEAT:
                begin
                    snd_byte = last_reg;
                end
                default:
                begin
                    snd_byte  = CODE_RESEND;
                    last_next = CODE_RESEND;
                end
            endcase
        end
    end

    // Build the first response item
    always_comb
    begin
        res.send_valid   = snd_valid;
        res.send_byte    = snd_byte;
        res.last_of_run  = !two_items;
        res.led_scroll   = led_next[0];
        res.led_num      = led_next[1];
        res.led_caps     = led_next[2];
        res.code_set     = set_next;
        res.delay_ms     = delay_ms_of(delay_next);
        res.rate_code    = rate_next;
        res.scan_enabled = enable_next;
    end

    // Control and keyboard state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            second_reg     <= 1'b0;
            pend_reg       <= ARG_NONE;
            last_reg       <= CODE_BAT_OK;
            led_reg        <= LEDS_ALL_ON;
            set_reg        <= SET_DEFAULT;
            delay_reg      <= DELAY_DEFAULT;
            rate_reg       <= RATE_DEFAULT;
            enable_reg     <= 1'b1;
        end
        else
        begin
            // Hold the host byte until the output side frees up
            if (cmd.ready)
            begin
                hold_valid_reg <= cmd.valid;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                second_reg    <= two_items;
                pend_reg      <= pend_next;
                last_reg      <= last_next;
                led_reg       <= led_next;
                set_reg       <= set_next;
                delay_reg     <= delay_next;
                rate_reg      <= rate_next;
                enable_reg    <= enable_next;
            end
            else if (out_fire)
            begin
                // Drop a finished item, or step to the trailing AA
                out_valid_reg <= second_reg;
                second_reg    <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            byte_reg <= cmd.host_byte;
        end

        if (advance)
        begin
            out_reg <= res;
        end
        else if (out_fire && second_reg)
        begin
            out_reg.send_byte   <= CODE_BAT_OK;
            out_reg.last_of_run <= 1'b1;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.send_valid   = out_reg.send_valid;
    assign rsp.send_byte    = out_reg.send_byte;
    assign rsp.last_of_run  = out_reg.last_of_run;
    assign rsp.led_scroll   = out_reg.led_scroll;
    assign rsp.led_num      = out_reg.led_num;
    assign rsp.led_caps     = out_reg.led_caps;
    assign rsp.code_set     = out_reg.code_set;
    assign rsp.delay_ms     = out_reg.delay_ms;
    assign rsp.rate_code    = out_reg.rate_code;
    assign rsp.scan_enabled = out_reg.scan_enabled;

    // Checks
    `PS2KBD_ASSERT_NOW(a_second_only_after_first, clk, rst_n,
        second_reg, out_valid_reg && !out_reg.last_of_run && out_reg.send_valid)
    `PS2KBD_ASSERT_NEXT(a_bat_follows_ack, clk, rst_n,
        out_fire && second_reg,
        out_valid_reg && out_reg.send_byte == CODE_BAT_OK && out_reg.last_of_run)
    `PS2KBD_ASSERT_NEXT(a_advance_fills_output, clk, rst_n,
        advance, out_valid_reg)
    `PS2KBD_ASSERT_NEXT(a_stalled_byte_held, clk, rst_n,
        hold_valid_reg && !advance, hold_valid_reg && $stable(byte_reg))
    `PS2KBD_ASSERT_NOW(a_silent_item_is_last, clk, rst_n,
        out_valid_reg && !out_reg.send_valid,
        out_reg.send_byte == 8'h00 && out_reg.last_of_run)

endmodule
